### design/phac_pkg.sv
// ----------------------------------------------------------------------------
// phac_pkg: shared types and constants of the path heading alignment cost core
// Holds sizes, opcodes, the sequencer states and the arctangent table.
// ----------------------------------------------------------------------------
package phac_pkg;

  localparam int PATH_DEPTH = 1024;
  localparam int IDX_W      = $clog2(PATH_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 32;
  localparam int VEC_W      = 45;
  localparam int ANG_W      = 18;
  localparam int Z_W        = 17;
  localparam int CORDIC_N   = 14;
  localparam int STEP_W     = 4;

  localparam logic signed [ANG_W-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [ANG_W-1:0] PI_HALF_Q13 = 18'sd12868;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SCORE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEG_A,
    ST_SEG_B,
    ST_SEG_C,
    ST_NORM,
    ST_CORDIC,
    ST_DONE
  } state_e;

  function automatic logic [Z_W-1:0] atan_q13(input logic [STEP_W-1:0] step);
    logic [Z_W-1:0] r;
    case (step)
      4'd0:    r = 17'd6434;
      4'd1:    r = 17'd3798;
      4'd2:    r = 17'd2007;
      4'd3:    r = 17'd1019;
      4'd4:    r = 17'd511;
      4'd5:    r = 17'd256;
      4'd6:    r = 17'd128;
      4'd7:    r = 17'd64;
      4'd8:    r = 17'd32;
      4'd9:    r = 17'd16;
      4'd10:   r = 17'd8;
      4'd11:   r = 17'd4;
      4'd12:   r = 17'd2;
      4'd13:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### design/phac_store.sv
// ----------------------------------------------------------------------------
// phac_store: path point memory
// Two arrays for x and y, each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module phac_store (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [phac_pkg::IDX_W-1:0]           waddr_i,
  input  logic signed [phac_pkg::COORD_W-1:0]  wx_i,
  input  logic signed [phac_pkg::COORD_W-1:0]  wy_i,
  input  logic [phac_pkg::IDX_W-1:0]           raddr_i,
  output logic signed [phac_pkg::COORD_W-1:0]  rx_o,
  output logic signed [phac_pkg::COORD_W-1:0]  ry_o
);

  logic signed [phac_pkg::COORD_W-1:0] mem_x [phac_pkg::PATH_DEPTH];
  logic signed [phac_pkg::COORD_W-1:0] mem_y [phac_pkg::PATH_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
  end

endmodule

### design/path_heading_alignment_cost_core.sv
// ----------------------------------------------------------------------------
// path_heading_alignment_cost_core: heading alignment score against a path
// Stores path points, finds the nearest point for each pose and sums the
// folded angle between pose heading and the path segment ending there.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Word
// command   in         start_i & !busy_o      opcode, pos_x, pos_y, heading, last
// result    out        valid_o, one cycle     angle_diff, sum, index, flags
//
// Clear, append and the unused opcode complete on acceptance; busy_o stays low.
// A score holds busy_o through the scan, the segment fetch, the doublings that
// normalise the segment and the CORDIC steps; the memory scan reads one point
// per cycle through a four-stage distance pipe. A short path goes straight to
// the result, and a zero-length segment skips the doublings and CORDIC steps.
// Reset clears the point count and the sum; the store itself is not cleared.
// The result strobe cannot be stalled: take the word in the cycle it shows.
//
module path_heading_alignment_cost_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           opcode_i,
  input  logic signed [phac_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [phac_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [15:0]                   heading_i,
  input  logic                                 last_sample_i,
  output logic                                 valid_o,
  output logic [13:0]                          angle_diff_o,
  output logic [31:0]                          heading_sum_o,
  output logic [9:0]                           nearest_index_o,
  output logic                                 plan_too_short_o,
  output logic                                 sum_final_o
);

  localparam int IW = phac_pkg::IDX_W;
  localparam int CW = phac_pkg::CNT_W;
  localparam int XW = phac_pkg::COORD_W;
  localparam int VW = phac_pkg::VEC_W;
  localparam int AW = phac_pkg::ANG_W;
  localparam int ZW = phac_pkg::Z_W;
  localparam int SW = phac_pkg::STEP_W;
  localparam int MW = XW + 1;
  localparam int DW = 2 * MW;

  // control
  phac_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   acc_q, acc_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          v0_q, v1_q, v2_q;
  logic          valid_q, valid_d;

  // payload
  logic signed [XW-1:0] px_q, py_q;
  logic signed [15:0]   hd_q;
  logic                 last_q;
  logic [IW-1:0]        idx0_q, idx1_q, idx2_q;
  logic [MW-1:0]        mx_q, my_q;
  logic [DW-2:0]        sqx_q, sqy_q;
  logic [DW-1:0]        best_q;
  logic [IW-1:0]        near_q, near_d;
  logic signed [XW-1:0] nx_q, ny_q;
  logic signed [VW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [SW-1:0]        step_q, step_d;
  logic [13:0]          diff_q, diff_d;
  logic                 short_q, short_d;
  logic [13:0]          diff_o_q;
  logic [31:0]          sum_o_q;
  logic [IW-1:0]        near_o_q;
  logic                 short_o_q, final_o_q;

  logic                 accept, mem_we, issuing, upd;
  logic [IW-1:0]        raddr;
  logic signed [XW-1:0] rx, ry;
  logic signed [MW-1:0] dx, dy;
  logic [DW-1:0]        dsq;
  logic [VW-1:0]        ax, ay, am;
  logic signed [VW-1:0] xs, ys;
  logic signed [AW-1:0] ang, ang_w, ang_a;
  logic [32:0]          sum_w;
  logic [31:0]          sum_sat;

  assign accept  = start_i && (state_q == phac_pkg::ST_IDLE);
  assign busy_o  = (state_q != phac_pkg::ST_IDLE);
  assign mem_we  = accept && (opcode_i == phac_pkg::OP_APPEND) &&
                   (cnt_q < CW'(phac_pkg::PATH_DEPTH));
  assign issuing = (state_q == phac_pkg::ST_SCAN) && (iss_q < cnt_q);

  phac_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wx_i    (pos_x_i),
    .wy_i    (pos_y_i),
    .raddr_i (raddr),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  // distance pipe: difference magnitudes, squares, then compare against best
  assign dx   = {rx[XW-1], rx} - {px_q[XW-1], px_q};
  assign dy   = {ry[XW-1], ry} - {py_q[XW-1], py_q};
  assign dsq  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign upd  = v2_q && ((idx2_q == IW'(1)) || (dsq < best_q));

  // shared vector unit operands
  assign ax = cx_q[VW-1] ? VW'(-cx_q) : VW'(cx_q);
  assign ay = cy_q[VW-1] ? VW'(-cy_q) : VW'(cy_q);
  assign am = (ax > ay) ? ax : ay;
  assign xs = cx_q >>> step_q;
  assign ys = cy_q >>> step_q;

  // heading minus segment angle, wrap into one turn, fold into a quarter
  always_comb begin
    ang = AW'(hd_q) - AW'(z_q);
    if (ang > phac_pkg::PI_Q13) begin
      ang_w = ang - (phac_pkg::PI_Q13 <<< 1);
    end else if (ang < -phac_pkg::PI_Q13) begin
      ang_w = ang + (phac_pkg::PI_Q13 <<< 1);
    end else begin
      ang_w = ang;
    end
    ang_a = ang_w[AW-1] ? -ang_w : ang_w;
    if (ang_a > phac_pkg::PI_HALF_Q13) begin
      ang_a = phac_pkg::PI_Q13 - ang_a;
    end
  end

  assign sum_w   = {1'b0, acc_q} + 33'(diff_q);
  assign sum_sat = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    iss_d   = iss_q;
    valid_d = 1'b0;
    near_d  = near_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    z_d     = z_q;
    step_d  = step_q;
    diff_d  = diff_q;
    short_d = short_q;
    raddr   = iss_q[IW-1:0];
    unique case (state_q)
      phac_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            phac_pkg::OP_CLEAR: begin
              cnt_d = '0;
              acc_d = '0;
            end
            phac_pkg::OP_APPEND: begin
              if (mem_we) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            phac_pkg::OP_SCORE: begin
              diff_d = '0;
              near_d = '0;
              iss_d  = CW'(1);
              if (cnt_q < CW'(2)) begin
                short_d = 1'b1;
                state_d = phac_pkg::ST_DONE;
              end else begin
                short_d = 1'b0;
                state_d = phac_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      phac_pkg::ST_SCAN: begin
        if (issuing) begin
          iss_d = iss_q + CW'(1);
        end
        if (upd) begin
          near_d = idx2_q;
        end
        if (!issuing && !v0_q && !v1_q && !v2_q) begin
          state_d = phac_pkg::ST_SEG_A;
        end
      end
      phac_pkg::ST_SEG_A: begin
        raddr   = near_q;
        state_d = phac_pkg::ST_SEG_B;
      end
      phac_pkg::ST_SEG_B: begin
        raddr   = near_q - IW'(1);
        state_d = phac_pkg::ST_SEG_C;
      end
      phac_pkg::ST_SEG_C: begin
        cx_d = VW'(nx_q) - VW'(rx);
        cy_d = VW'(ny_q) - VW'(ry);
        if ((nx_q == rx) && (ny_q == ry)) begin
          state_d = phac_pkg::ST_DONE;
        end else begin
          state_d = phac_pkg::ST_NORM;
        end
      end
      phac_pkg::ST_NORM: begin
        if (am < (VW'(1) << 40)) begin
          cx_d = cx_q <<< 1;
          cy_d = cy_q <<< 1;
        end else begin
          step_d  = '0;
          state_d = phac_pkg::ST_CORDIC;
          if (cx_q[VW-1]) begin
            // pre-rotate by a half turn
            z_d  = cy_q[VW-1] ? -ZW'(phac_pkg::PI_Q13) : ZW'(phac_pkg::PI_Q13);
            cx_d = -cx_q;
            cy_d = -cy_q;
          end else begin
            z_d = '0;
          end
        end
      end
      phac_pkg::ST_CORDIC: begin
        if (step_q == SW'(phac_pkg::CORDIC_N)) begin
          // rotation settled: take the folded angle
          diff_d  = ang_a[13:0];
          state_d = phac_pkg::ST_DONE;
        end else begin
          if (!cy_q[VW-1] && (cy_q != '0)) begin
            cx_d = cx_q + ys;
            cy_d = cy_q - xs;
            z_d  = z_q + $signed(phac_pkg::atan_q13(step_q));
          end else begin
            cx_d = cx_q - ys;
            cy_d = cy_q + xs;
            z_d  = z_q - $signed(phac_pkg::atan_q13(step_q));
          end
          step_d = step_q + SW'(1);
        end
      end
      phac_pkg::ST_DONE: begin
        valid_d = 1'b1;
        acc_d   = last_q ? 32'd0 : sum_sat;
        state_d = phac_pkg::ST_IDLE;
      end
      default: begin
        state_d = phac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= phac_pkg::ST_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      iss_q   <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      iss_q   <= iss_d;
      v0_q    <= issuing;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      hd_q   <= heading_i;
      last_q <= last_sample_i;
    end
    idx0_q  <= iss_q[IW-1:0];
    idx1_q  <= idx0_q;
    idx2_q  <= idx1_q;
    mx_q    <= dx[MW-1] ? MW'(-dx) : MW'(dx);
    my_q    <= dy[MW-1] ? MW'(-dy) : MW'(dy);
    sqx_q   <= (DW-1)'(mx_q * mx_q);
    sqy_q   <= (DW-1)'(my_q * my_q);
    if (upd) begin
      best_q <= dsq;
    end
    if (state_q == phac_pkg::ST_SEG_B) begin
      nx_q <= rx;
      ny_q <= ry;
    end
    near_q  <= near_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    z_q     <= z_d;
    step_q  <= step_d;
    short_q <= short_d;
    diff_q  <= diff_d;
    if (state_q == phac_pkg::ST_DONE) begin
      diff_o_q  <= diff_q;
      sum_o_q   <= sum_sat;
      near_o_q  <= near_q;
      short_o_q <= short_q;
      final_o_q <= last_q;
    end
  end

  assign valid_o          = valid_q;
  assign angle_diff_o     = diff_o_q;
  assign heading_sum_o    = sum_o_q;
  assign nearest_index_o  = 10'(near_o_q);
  assign plan_too_short_o = short_o_q;
  assign sum_final_o      = final_o_q;

  // the result word is shown only once the sequencer is back at rest
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result shown while busy");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && plan_too_short_o) |-> (angle_diff_o == 14'd0 && nearest_index_o == 10'd0))
    else $error("short path gave a nonzero result");

  a_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (angle_diff_o <= 14'd12868)) else $error("angle not folded");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(phac_pkg::PATH_DEPTH)) else $error("point count overrun");

  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !plan_too_short_o) |-> (nearest_index_o != 10'd0))
    else $error("nearest index zero on a scored path");

endmodule
